@@ src/bitrd_pkg.sv @@
// ----------------------------------------------------------------------------
// bitrd_pkg
// Shared types and constants for the word stream bit reader.
// ----------------------------------------------------------------------------
package bitrd_pkg;

	localparam int WORD_BITS     = 32;
	localparam int BYTE_BITS     = 8;
	localparam int DEF_MAX_WORDS = 256;
	localparam int CNT_W         = 9;
	localparam int ADDR_W        = 8;
	localparam int BITCNT_W      = 6;
	localparam int POS_W         = 5;

	localparam logic [CNT_W-1:0] CNT_RESET = 9'd256;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_ALIGN  = 2'd2,
		OP_REWIND = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t               opcode;
		logic [ADDR_W-1:0]     word_address;
		logic [WORD_BITS-1:0]  word_value;
		logic [BITCNT_W-1:0]   bit_count;
	} item_t;

	// field_value in the lowest bits
	typedef struct packed {
		logic                  padding_nonzero;
		logic                  overflow;
		logic [WORD_BITS-1:0]  field_value;
	} result_t;

endpackage

@@ src/word_stream_bit_reader.sv @@
// ----------------------------------------------------------------------------
// word_stream_bit_reader
// Path: request beats pass the core input register, results the output buffer.
// Throughput: one request per cycle while the output buffer has room, set by
// the window and position update on the registered request.
// Reset: position, window and handshake state clear; buffer_word_count goes
// to 256; the word store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module word_stream_bit_reader #(
	parameter int MAX_WORDS = bitrd_pkg::DEF_MAX_WORDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,      // buffer_word_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // word_address, word_value, bit_count
	input  logic [1:0]  s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // field_value, overflow, padding_nonzero
);
	import bitrd_pkg::*;

	item_t   in_item;
	result_t res_item;
	result_t out_item;
	logic    res_push;
	logic    res_ready;

	assign cfg_ready = 1'b1;

	always_comb begin
		in_item.opcode       = opcode_t'(s_axis_tuser);
		in_item.word_address = s_axis_tdata[7:0];
		in_item.word_value   = s_axis_tdata[39:8];
		in_item.bit_count    = s_axis_tdata[45:40];
	end

	bitrd_core #(
		.MAX_WORDS (MAX_WORDS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.res_push  (res_push),
		.res_item  (res_item),
		.res_ready (res_ready)
	);

	bitrd_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_push),
		.push_data  (res_item),
		.push_ready (res_ready),
		.out_valid  (m_axis_tvalid),
		.out_data   (out_item),
		.out_ready  (m_axis_tready)
	);

	assign m_axis_tdata = {6'd0, out_item};

endmodule

@@ src/bitrd_core.sv @@
// ----------------------------------------------------------------------------
// bitrd_core
// Input register, word store with prefetched next word, bit window and
// position update; one item resolved per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module bitrd_core #(
	parameter int MAX_WORDS = bitrd_pkg::DEF_MAX_WORDS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [bitrd_pkg::CNT_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bitrd_pkg::item_t              in_item,
	output logic                          res_push,
	output bitrd_pkg::result_t            res_item,
	input  logic                          res_ready
);
	import bitrd_pkg::*;

	localparam int AW = $clog2(MAX_WORDS);
	localparam int PW = $clog2(MAX_WORDS + 2);
	localparam int XW = PW + CNT_W;
	localparam int TW = XW + POS_W;

	logic                 valid_s1;
	item_t                item_s1;
	logic [CNT_W-1:0]     cnt_q;
	logic [PW-1:0]        word_pos_q;
	logic [POS_W-1:0]     bit_pos_q;
	logic [WORD_BITS-1:0] window_q;
	logic [WORD_BITS-1:0] word0_q;
	logic [WORD_BITS-1:0] next_word_q;
	logic [WORD_BITS-1:0] mem [MAX_WORDS];

	logic                 adv;
	logic [XW-1:0]        cnt_x;
	logic [XW-1:0]        max_x;
	logic [XW-1:0]        cnt_eff;
	logic [TW-1:0]        total_bits;
	logic [TW-1:0]        consumed;
	logic [XW-1:0]        next_idx;
	logic [WORD_BITS-1:0] next_eff;
	logic [WORD_BITS-1:0] rew_word;
	logic [BITCNT_W-1:0]  take_n;
	logic                 do_take;
	logic                 ovf;
	logic                 ok;
	logic [BITCNT_W-1:0]  bit_sum;
	logic                 cross_word;
	logic [2*WORD_BITS-1:0] cat;
	logic [2*WORD_BITS-1:0] sh;
	logic [PW-1:0]        nxt_pos;
	logic [XW-1:0]        rd_addr;
	logic [XW-1:0]        wa_x;
	logic                 wr_en;

	assign in_ready = !valid_s1 || res_ready;
	assign adv      = valid_s1 && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		cnt_x      = XW'(cnt_q);
		max_x      = XW'(MAX_WORDS);
		cnt_eff    = (cnt_x > max_x) ? max_x : cnt_x;
		total_bits = {cnt_eff, {POS_W{1'b0}}};
		consumed   = {XW'(word_pos_q), bit_pos_q};
		next_idx   = XW'(word_pos_q) + XW'(1);
		next_eff   = (next_idx < cnt_eff) ? next_word_q : '0;
		rew_word   = (cnt_eff != '0) ? word0_q : '0;

		case (item_s1.opcode)
			OP_READ: begin
				take_n = (item_s1.bit_count > BITCNT_W'(WORD_BITS)) ?
					BITCNT_W'(WORD_BITS) : item_s1.bit_count;
			end
			OP_ALIGN: begin
				take_n = (consumed[2:0] == 3'd0) ? '0 :
					BITCNT_W'(BYTE_BITS) - BITCNT_W'(consumed[2:0]);
			end
			default: begin
				take_n = '0;
			end
		endcase

		do_take    = (item_s1.opcode inside {OP_READ, OP_ALIGN}) && (take_n != '0);
		ovf        = do_take && ((consumed + TW'(take_n)) > total_bits);
		ok         = do_take && !ovf;
		bit_sum    = BITCNT_W'(bit_pos_q) + take_n;
		cross_word = bit_sum[BITCNT_W-1];
		cat        = {{WORD_BITS{1'b0}}, window_q} << take_n;
		sh         = cat | ({{WORD_BITS{1'b0}},
			cross_word ? next_eff : {WORD_BITS{1'b0}}} << bit_sum[POS_W-1:0]);

		res_item.field_value     = (ok && item_s1.opcode == OP_READ) ?
			sh[2*WORD_BITS-1:WORD_BITS] : '0;
		res_item.overflow        = ovf;
		res_item.padding_nonzero = ok && (item_s1.opcode == OP_ALIGN) &&
			(sh[2*WORD_BITS-1:WORD_BITS] != '0);

		nxt_pos = word_pos_q;
		if (adv && ok && cross_word) begin
			nxt_pos = word_pos_q + PW'(1);
		end
		if (adv && item_s1.opcode == OP_REWIND) begin
			nxt_pos = '0;
		end
		rd_addr = XW'(nxt_pos) + XW'(1);
		wa_x    = XW'(item_s1.word_address);
		wr_en   = adv && (item_s1.opcode == OP_WRITE) && (wa_x < max_x);
	end

	assign res_push = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= CNT_RESET;
			word_pos_q <= '0;
			bit_pos_q  <= '0;
			window_q   <= '0;
		end else begin
			if (cfg_valid) begin
				cnt_q <= cfg_data;
			end
			if (adv) begin
				if (item_s1.opcode == OP_REWIND) begin
					word_pos_q <= '0;
					bit_pos_q  <= '0;
					window_q   <= rew_word;
				end else if (ok) begin
					word_pos_q <= nxt_pos;
					bit_pos_q  <= bit_sum[POS_W-1:0];
					window_q   <= sh[WORD_BITS-1:0];
				end
			end
		end
	end

	// store, shadow of word 0 and prefetch of the word after the current one
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa_x[AW-1:0]] <= item_s1.word_value;
		end
		if (wr_en && wa_x == '0) begin
			word0_q <= item_s1.word_value;
		end
		if (wr_en && wa_x == rd_addr) begin
			next_word_q <= item_s1.word_value;
		end else begin
			next_word_q <= mem[rd_addr[AW-1:0]];
		end
	end

	a_window_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(window_q & ((32'd1 << bit_pos_q) - 32'd1)) == 32'd0)
		else $error("window holds bits below the read position");

	a_ovf_holds_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ovf) |=> (word_pos_q == $past(word_pos_q)) &&
		(bit_pos_q == $past(bit_pos_q)) && (window_q == $past(window_q)))
		else $error("overflowed request moved the position");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(word_pos_q != $past(word_pos_q)) |->
		((word_pos_q == $past(word_pos_q) + PW'(1)) || (word_pos_q == '0)))
		else $error("word position jumped");

endmodule

@@ src/bitrd_obuf.sv @@
// ----------------------------------------------------------------------------
// bitrd_obuf
// Two-entry output buffer: result register plus skid register, so the
// upstream ready comes straight from a flop.
// ----------------------------------------------------------------------------
module bitrd_obuf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bitrd_pkg::result_t push_data,
	output logic               push_ready,
	output logic               out_valid,
	output bitrd_pkg::result_t out_data,
	input  logic               out_ready
);
	import bitrd_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_data_q;
	result_t skid_data_q;

	assign push_ready = !skid_valid_q;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty result register");

endmodule

@@ tb/sv/word_stream_bit_reader_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_stream_bit_reader_test
// Self-checking bench for the MSB-first bit reader. A short directed list
// covers the field extremes, every opcode, zero and oversized bit counts,
// the exact end of the buffer, overflow and a lowered word count. Random
// phases follow after the whole store is filled. Each phase sets a new word
// count while the block is idle. A local model of the window predicts each
// result beat that the plan does not fix, and each beat is compared field by
// field. Both sides idle at random. One phase runs with no idling at all. In
// another the sink holds off for a long stretch.
// ----------------------------------------------------------------------------
module word_stream_bit_reader_test;
	import bitrd_pkg::*;

	localparam int LIMIT        = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 1420;
	localparam int IDLE_PCT     = 11;

	typedef enum logic {ROW_BEAT, ROW_COUNT} row_kind_t;

	typedef struct packed {
		logic    fixed;
		result_t want;
	} note_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [CNT_W-1:0]   count;
		item_t              it;
		note_t              nt;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // word_address, word_value, bit_count
	logic [1:0]  s_axis_tuser = '0;   // opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // field_value, overflow, padding_nonzero

	word_stream_bit_reader uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// window model
	logic [WORD_BITS-1:0] store_model [DEF_MAX_WORDS];
	logic [CNT_W-1:0]     count_reg = CNT_RESET;
	logic [WORD_BITS-1:0] window_model = '0;
	int unsigned          bit_ofs = 0;
	int unsigned          word_idx = 0;
	int unsigned          bits_taken = 0;

	note_t   note_q [$];
	result_t field_q [$];
	int      items_sent = 0;
	int      results_seen = 0;
	int      faults = 0;
	int      cycle_count = 0;
	logic    steady = 1'b0;
	logic    hold_req = 1'b0;

	function automatic int unsigned live_words();
		return (count_reg > DEF_MAX_WORDS) ? DEF_MAX_WORDS : count_reg;
	endfunction

	function automatic logic [WORD_BITS-1:0] fetch_word(int unsigned idx);
		if (idx < live_words() && idx < DEF_MAX_WORDS)
			return store_model[idx];
		return '0;
	endfunction

	function automatic logic [WORD_BITS-1:0] pull_bits(int unsigned n, output logic ovf);
		logic [63:0] w;
		int unsigned rem;
		if (bits_taken + n > live_words() * WORD_BITS) begin
			ovf = 1'b1;
			return '0;
		end
		ovf = 1'b0;
		bits_taken += n;
		w = {32'd0, window_model};
		if (bit_ofs + n < WORD_BITS) begin
			w = w << n;
			bit_ofs += n;
		end else begin
			rem = WORD_BITS - bit_ofs;
			word_idx++;
			w = w << rem;
			w = w | {32'd0, fetch_word(word_idx)};
			w = w << (n - rem);
			bit_ofs = n - rem;
		end
		window_model = w[31:0];
		return w[63:32];
	endfunction

	function automatic result_t predict_field(item_t it);
		result_t r;
		int unsigned n;
		logic [WORD_BITS-1:0] v;
		logic ovf;
		r = '0;
		case (it.opcode)
			OP_WRITE: begin
				store_model[it.word_address] = it.word_value;
			end
			OP_READ: begin
				n = (it.bit_count > WORD_BITS) ? WORD_BITS : it.bit_count;
				if (n != 0) begin
					r.field_value = pull_bits(n, ovf);
					r.overflow = ovf;
				end
			end
			OP_ALIGN: begin
				n = bits_taken % BYTE_BITS;
				if (n != 0) begin
					v = pull_bits(BYTE_BITS - n, ovf);
					r.overflow = ovf;
					r.padding_nonzero = !ovf && (v != 0);
				end
			end
			OP_REWIND: begin
				bits_taken = 0;
				bit_ofs = 0;
				word_idx = 0;
				window_model = fetch_word(0);
			end
		endcase
		return r;
	endfunction

	// predict on each request beat, check each result beat
	always @(posedge clk) begin
		item_t   it;
		result_t r;
		result_t got;
		note_t   nt;
		cycle_count <= cycle_count + 1;
		if (arst_n && cfg_valid && cfg_ready)
			count_reg = cfg_data;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			it.opcode = opcode_t'(s_axis_tuser);
			it.word_address = s_axis_tdata[7:0];
			it.word_value = s_axis_tdata[39:8];
			it.bit_count = s_axis_tdata[45:40];
			r = predict_field(it);
			nt = note_q.pop_front();
			field_q.push_back(nt.fixed ? nt.want : r);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			got = m_axis_tdata[33:0];
			if (field_q.size() == 0) begin
				$error("result beat with nothing pending: %h", m_axis_tdata);
				faults++;
			end else begin
				r = field_q.pop_front();
				if (got.field_value !== r.field_value) begin
					$error("field_value: expected %h, got %h", r.field_value, got.field_value);
					faults++;
				end
				if (got.overflow !== r.overflow) begin
					$error("overflow: expected %b, got %b", r.overflow, got.overflow);
					faults++;
				end
				if (got.padding_nonzero !== r.padding_nonzero) begin
					$error("padding_nonzero: expected %b, got %b",
						r.padding_nonzero, got.padding_nonzero);
					faults++;
				end
			end
		end
		if (cycle_count > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// sink: random back-pressure, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_beat(input item_t it, input note_t nt);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		note_q.push_back(nt);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, it.bit_count, it.word_value, it.word_address};
		s_axis_tuser <= it.opcode;
		items_sent++;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
	endtask

	task automatic set_count(input logic [CNT_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [WORD_BITS-1:0] rand_word();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int unsigned r;
		it.word_address = ADDR_W'($urandom);
		it.word_value = rand_word();
		it.bit_count = BITCNT_W'($urandom_range(63));
		if ($urandom_range(99) < 85)
			it.bit_count = BITCNT_W'($urandom_range(1, 32));
		r = $urandom_range(99);
		if (r < 10)
			it.opcode = OP_WRITE;
		else if (r < 13)
			it.opcode = OP_REWIND;
		else if (r < 25)
			it.opcode = OP_ALIGN;
		else
			it.opcode = OP_READ;
		return it;
	endfunction

	function automatic step_row_t beat(opcode_t op, int unsigned addr, logic [31:0] val,
			int unsigned n);
		step_row_t row;
		row = '0;
		row.kind = ROW_BEAT;
		row.it.opcode = op;
		row.it.word_address = ADDR_W'(addr);
		row.it.word_value = val;
		row.it.bit_count = BITCNT_W'(n);
		return row;
	endfunction

	function automatic step_row_t beat_is(opcode_t op, int unsigned addr, logic [31:0] val,
			int unsigned n, logic [31:0] fv, logic ov, logic pad);
		step_row_t row;
		row = beat(op, addr, val, n);
		row.nt.fixed = 1'b1;
		row.nt.want.field_value = fv;
		row.nt.want.overflow = ov;
		row.nt.want.padding_nonzero = pad;
		return row;
	endfunction

	function automatic step_row_t count_row(int unsigned v);
		step_row_t row;
		row = '0;
		row.kind = ROW_COUNT;
		row.count = CNT_W'(v);
		return row;
	endfunction

	initial begin
		step_row_t   plan [$];
		item_t       it;
		int unsigned phase;
		int unsigned done;
		int unsigned len;
		int unsigned cnt;

		// read before rewind sees the cleared window
		plan.push_back(beat_is(OP_READ,   0, 32'h0, 8, 32'h0, 1'b0, 1'b0));
		plan.push_back(beat_is(OP_ALIGN,  0, 32'h0, 0, 32'h0, 1'b0, 1'b0));
		plan.push_back(count_row(2));
		plan.push_back(beat_is(OP_WRITE,  0, 32'hFFFF_FFFF, 0, 32'h0, 1'b0, 1'b0));
		plan.push_back(beat_is(OP_WRITE,  1, 32'hA5C3_0F96, 32, 32'h0, 1'b0, 1'b0));
		plan.push_back(beat_is(OP_WRITE,  255, 32'h0, 63, 32'h0, 1'b0, 1'b0));
		plan.push_back(beat_is(OP_REWIND, 0, 32'h0, 0, 32'h0, 1'b0, 1'b0));
		// rewrite a word already in the window
		plan.push_back(beat_is(OP_WRITE,  0, 32'h0, 0, 32'h0, 1'b0, 1'b0));
		plan.push_back(beat_is(OP_READ,   0, 32'h0, 0, 32'h0, 1'b0, 1'b0));
		plan.push_back(beat(OP_READ,      0, 32'h0, 1));
		plan.push_back(beat(OP_READ,      0, 32'h0, 3));
		plan.push_back(beat(OP_ALIGN,     0, 32'h0, 0));
		plan.push_back(beat(OP_READ,      0, 32'h0, 63));
		// ends exactly on the last valid bit
		plan.push_back(beat(OP_READ,      0, 32'h0, 24));
		plan.push_back(beat_is(OP_READ,   0, 32'h0, 1, 32'h0, 1'b1, 1'b0));
		plan.push_back(beat_is(OP_REWIND, 0, 32'h0, 0, 32'h0, 1'b0, 1'b0));
		plan.push_back(beat(OP_READ,      0, 32'h0, 32));
		plan.push_back(beat(OP_READ,      0, 32'h0, 31));
		// count lowered below the current position
		plan.push_back(count_row(1));
		plan.push_back(beat_is(OP_ALIGN,  0, 32'h0, 0, 32'h0, 1'b1, 1'b0));
		plan.push_back(beat_is(OP_READ,   0, 32'h0, 32, 32'h0, 1'b1, 1'b0));
		plan.push_back(count_row(0));
		plan.push_back(beat_is(OP_REWIND, 0, 32'h0, 0, 32'h0, 1'b0, 1'b0));
		plan.push_back(beat_is(OP_READ,   0, 32'h0, 1, 32'h0, 1'b1, 1'b0));
		plan.push_back(count_row(511));
		plan.push_back(beat(OP_READ,      0, 32'h0, 5));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_COUNT)
				set_count(plan[i].count);
			else
				send_beat(plan[i].it, plan[i].nt);
		end

		// fill the whole store before any random load
		for (int a = 0; a < DEF_MAX_WORDS; a++) begin
			it = rand_item();
			it.opcode = OP_WRITE;
			it.word_address = ADDR_W'(a);
			send_beat(it, '0);
		end

		phase = 0;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			case (phase)
				0: cnt = 256;
				1: cnt = 1;
				2: cnt = 511;
				3: cnt = 0;
				default: cnt = ($urandom_range(3) == 0) ? $urandom_range(257, 511)
					: $urandom_range(1, 256);
			endcase
			set_count(CNT_W'(cnt));
			steady = (phase == 2);
			hold_req = (phase == 4);
			if ($urandom_range(9) < 7) begin
				it = rand_item();
				it.opcode = OP_REWIND;
				send_beat(it, '0);
				done++;
			end
			len = (phase == 4) ? 120 : $urandom_range(20, 160);
			repeat (len) begin
				send_beat(rand_item(), '0);
				done++;
			end
			phase++;
		end

		drain();
		repeat (8) @(posedge clk);
		if (faults == 0 && field_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ word_stream_bit_reader.f @@
src/bitrd_pkg.sv
src/bitrd_core.sv
src/bitrd_obuf.sv
src/word_stream_bit_reader.sv
tb/sv/word_stream_bit_reader_test.sv
